// File: sv/cholesky_spd_solver_assert.svh
// Assertion macros used by the solver sequencer.
// Needs no other file; define NO_ASSERTIONS to compile them out.
`ifndef CHOLESKY_SPD_SOLVER_ASSERT_SVH
`define CHOLESKY_SPD_SOLVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSOLV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("cholesky_spd_solver: implication check failed");
`define CSOLV_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("cholesky_spd_solver: next-cycle check failed");
`else
`define CSOLV_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define CSOLV_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/csolv_pkg.sv
// Shared types and constants of the Cholesky solver.
// No dependencies; used by the sequencer, the divide/square-root unit and the top level.
`default_nettype none
package csolv_pkg;

	localparam int MAX_SIZE = 8;
	localparam logic [3:0] SIZE_RESET = 4'd8;

	typedef struct packed {
		logic [2:0]         row;
		logic [3:0]         col;
		logic signed [31:0] value;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         index;
		logic signed [31:0] solution;
		logic               failed;
		logic               final_res;
	} out_item_t;

	typedef enum logic {
		OP_DIV,
		OP_SQRT
	} unit_op_t;

	typedef struct packed {
		logic               start;
		unit_op_t           op;
		logic signed [31:0] num;
		logic [31:0]        den;
	} unit_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic signed [31:0] result;
	} unit_rsp_t;

endpackage
`default_nettype wire

// File: sv/csolv_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none
module csolv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: sv/csolv_divsqrt.sv
// Shared iterative unit: Q16.16 quotient (one bit per cycle) and square root
// (one bit pair per cycle). Depends on csolv_pkg.
`default_nettype none
module csolv_divsqrt (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire csolv_pkg::unit_req_t req,
	output csolv_pkg::unit_rsp_t      rsp
);

	logic                busy_q;
	logic                done_q;
	csolv_pkg::unit_op_t op_q;
	logic [5:0]          cnt_q;
	logic                neg_q;
	logic [31:0]         d_q;
	logic [32:0]         rem_q;
	logic [47:0]         dvd_q;
	logic [23:0]         root_q;
	logic [26:0]         sqrem_q;
	logic signed [31:0]  res_q;

	logic [31:0] mag;
	logic [32:0] dtrial;
	logic [26:0] r2;
	logic [26:0] strial;

	always_comb begin
		mag    = req.num[31] ? (32'd0 - req.num) : req.num;
		dtrial = {rem_q[31:0], dvd_q[47]};
		r2     = {sqrem_q[24:0], dvd_q[47:46]};
		strial = {1'b0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q  <= 1'b1;
				op_q    <= req.op;
				neg_q   <= req.num[31];
				d_q     <= req.den;
				rem_q   <= '0;
				sqrem_q <= '0;
				root_q  <= '0;
				if (req.op == csolv_pkg::OP_SQRT) begin
					dvd_q <= {req.num, 16'd0};
					cnt_q <= 6'd24;
				end else begin
					dvd_q <= {mag, 16'd0};
					cnt_q <= 6'd48;
				end
			end else if (busy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
				if (op_q == csolv_pkg::OP_SQRT) begin
					dvd_q <= {dvd_q[45:0], 2'b00};
					if (r2 >= strial) begin
						sqrem_q <= r2 - strial;
						root_q  <= {root_q[22:0], 1'b1};
					end else begin
						sqrem_q <= r2;
						root_q  <= {root_q[22:0], 1'b0};
					end
				end else begin
					if (dtrial >= {1'b0, d_q}) begin
						rem_q <= dtrial - {1'b0, d_q};
						dvd_q <= {dvd_q[46:0], 1'b1};
					end else begin
						rem_q <= dtrial;
						dvd_q <= {dvd_q[46:0], 1'b0};
					end
				end
			end else if (busy_q) begin
				// Final cycle: sign and saturation of the result.
				busy_q <= 1'b0;
				done_q <= 1'b1;
				if (op_q == csolv_pkg::OP_SQRT) begin
					res_q <= {8'd0, root_q};
				end else if (!neg_q) begin
					res_q <= (dvd_q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
						: dvd_q[31:0];
				end else begin
					res_q <= (dvd_q > 48'h0000_8000_0000) ? 32'sh8000_0000
						: (32'd0 - dvd_q[31:0]);
				end
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule
`default_nettype wire

// File: sv/csolv_seq.sv
// Solver sequencer: load writes, factorization, both substitutions and result
// readout over two RAMs. Depends on csolv_pkg, csolv_ram, csolv_divsqrt, assert header.
`default_nettype none
`include "cholesky_spd_solver_assert.svh"
module csolv_seq #(
	parameter int MAX_SIZE = csolv_pkg::MAX_SIZE
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [3:0]           size_cfg,
	input  wire logic                 ld_valid,
	output logic                      ld_ready,
	input  wire csolv_pkg::in_item_t  ld_item,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output csolv_pkg::out_item_t      res_item
);

	localparam int CW  = $clog2(MAX_SIZE + 1);
	localparam int MD  = MAX_SIZE * MAX_SIZE;
	localparam int MAW = (MD > 1) ? $clog2(MD) : 1;
	localparam int RAW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_RD_S, S_LD_S, S_RD_A, S_LD_A, S_LD_B, S_MUL, S_RND,
		S_ACC, S_FIN, S_LD_D, S_WAIT, S_ORD, S_OLD, S_EMIT, S_FAIL
	} state_t;

	typedef enum logic [1:0] {
		PH_FACT, PH_FWD, PH_BWD, PH_OUT
	} phase_t;

	state_t                state_q;
	phase_t                phase_q;
	logic [CW-1:0]         i_q, j_q, p_q, k_q;
	logic signed [31:0]    s_q, a_q, b_q, t_q, ljj_q;
	logic signed [63:0]    prod_q;
	csolv_pkg::out_item_t  res_q;

	logic                  mat_we, rhs_we;
	logic [MAW-1:0]        mat_waddr, mat_raddr;
	logic [RAW-1:0]        rhs_waddr, rhs_raddr;
	logic [31:0]           mat_wdata, rhs_wdata, mat_rdata, rhs_rdata;
	csolv_pkg::unit_req_t  ureq;
	csolv_pkg::unit_rsp_t  ursp;
	logic [CW-1:0]         p_start, p_end, p_next;
	logic signed [63:0]    rnd_sum, rnd_sh;
	logic signed [32:0]    diff;

	function automatic logic [MAW-1:0] maddr(input int r, input int c);
		return MAW'(r * MAX_SIZE + c);
	endfunction

	csolv_ram #(.WIDTH(32), .DEPTH(MD)) u_mat (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
		.raddr(mat_raddr), .rdata(mat_rdata)
	);

	csolv_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_rhs (
		.clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata(rhs_wdata),
		.raddr(rhs_raddr), .rdata(rhs_rdata)
	);

	csolv_divsqrt u_unit (.clk(clk), .arst_n(arst_n), .req(ureq), .rsp(ursp));

	always_comb begin
		case (phase_q)
			PH_FACT: p_end = j_q;
			PH_FWD:  p_end = i_q;
			default: p_end = k_q;
		endcase
		p_start = (phase_q == PH_BWD) ? (i_q + CW'(1)) : '0;
		p_next  = p_q + CW'(1);
		rnd_sum = prod_q + 64'sd32768;
		rnd_sh  = rnd_sum >>> 16;
		diff    = {s_q[31], s_q} - {t_q[31], t_q};
	end

	// Memory ports and unit request.
	always_comb begin
		mat_raddr = maddr(int'(i_q), int'(j_q));
		rhs_raddr = RAW'(i_q);
		case (state_q)
			S_RD_A: begin
				mat_raddr = (phase_q == PH_BWD) ? maddr(int'(p_q), int'(i_q))
					: maddr(int'(i_q), int'(p_q));
				rhs_raddr = RAW'(p_q);
			end
			S_LD_A:  mat_raddr = maddr(int'(j_q), int'(p_q));
			S_FIN:   mat_raddr = maddr(int'(i_q), int'(i_q));
			default: ;
		endcase

		mat_we    = 1'b0;
		rhs_we    = 1'b0;
		mat_waddr = maddr(int'(ld_item.row), int'(ld_item.col));
		rhs_waddr = RAW'(ld_item.row);
		mat_wdata = ld_item.value;
		rhs_wdata = ld_item.value;
		if (state_q == S_IDLE && ld_valid && ld_item.row < MAX_SIZE) begin
			mat_we = ld_item.col < MAX_SIZE;
			rhs_we = ld_item.col == MAX_SIZE;
		end else if (state_q == S_WAIT && ursp.done) begin
			mat_waddr = maddr(int'(i_q), int'(j_q));
			rhs_waddr = RAW'(i_q);
			mat_wdata = ursp.result;
			rhs_wdata = ursp.result;
			mat_we    = phase_q == PH_FACT;
			rhs_we    = phase_q != PH_FACT;
		end

		ureq.start = 1'b0;
		ureq.op    = csolv_pkg::OP_DIV;
		ureq.num   = s_q;
		ureq.den   = ljj_q;
		if (state_q == S_FIN && phase_q == PH_FACT
			&& !(i_q == j_q && (s_q[31] || s_q == '0))) begin
			ureq.start = 1'b1;
			ureq.op    = (i_q == j_q) ? csolv_pkg::OP_SQRT : csolv_pkg::OP_DIV;
		end else if (state_q == S_LD_D) begin
			ureq.start = 1'b1;
			ureq.den   = mat_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_FACT;
			i_q     <= '0;
			j_q     <= '0;
			p_q     <= '0;
			k_q     <= CW'(1);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ld_valid && ld_item.last) begin
						if (size_cfg == '0) begin
							k_q <= CW'(1);
						end else if (size_cfg > MAX_SIZE) begin
							k_q <= CW'(MAX_SIZE);
						end else begin
							k_q <= CW'(size_cfg);
						end
						phase_q <= PH_FACT;
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_RD_S;
					end
				end
				S_RD_S: state_q <= S_LD_S;
				S_LD_S: begin
					s_q     <= (phase_q == PH_FACT) ? mat_rdata : rhs_rdata;
					p_q     <= p_start;
					state_q <= (p_start == p_end) ? S_FIN : S_RD_A;
				end
				S_RD_A: state_q <= S_LD_A;
				S_LD_A: begin
					a_q <= mat_rdata;
					if (phase_q == PH_FACT) begin
						state_q <= S_LD_B;
					end else begin
						b_q     <= rhs_rdata;
						state_q <= S_MUL;
					end
				end
				S_LD_B: begin
					b_q     <= mat_rdata;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= a_q * b_q;
					state_q <= S_RND;
				end
				S_RND: begin
					if (rnd_sh > 64'sh7FFF_FFFF) begin
						t_q <= 32'sh7FFF_FFFF;
					end else if (rnd_sh < -64'sh8000_0000) begin
						t_q <= 32'sh8000_0000;
					end else begin
						t_q <= rnd_sh[31:0];
					end
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (diff > 33'sh0_7FFF_FFFF) begin
						s_q <= 32'sh7FFF_FFFF;
					end else if (diff < -33'sh0_8000_0000) begin
						s_q <= 32'sh8000_0000;
					end else begin
						s_q <= diff[31:0];
					end
					p_q     <= p_next;
					state_q <= (p_next == p_end) ? S_FIN : S_RD_A;
				end
				S_FIN: begin
					if (phase_q != PH_FACT) begin
						state_q <= S_LD_D;
					end else if (i_q == j_q && (s_q[31] || s_q == '0)) begin
						res_q   <= '{index: '0, solution: '0, failed: 1'b1,
							final_res: 1'b1};
						state_q <= S_FAIL;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_LD_D: state_q <= S_WAIT;
				S_WAIT: begin
					if (ursp.done) begin
						state_q <= S_RD_S;
						case (phase_q)
							PH_FACT: begin
								if (i_q == j_q) begin
									ljj_q <= ursp.result;
								end
								if (i_q + CW'(1) == k_q) begin
									if (j_q + CW'(1) == k_q) begin
										phase_q <= PH_FWD;
										i_q     <= '0;
									end else begin
										j_q <= j_q + CW'(1);
										i_q <= j_q + CW'(1);
									end
								end else begin
									i_q <= i_q + CW'(1);
								end
							end
							PH_FWD: begin
								if (i_q + CW'(1) == k_q) begin
									phase_q <= PH_BWD;
									i_q     <= k_q - CW'(1);
								end else begin
									i_q <= i_q + CW'(1);
								end
							end
							default: begin
								if (i_q == '0) begin
									phase_q <= PH_OUT;
									state_q <= S_ORD;
								end else begin
									i_q <= i_q - CW'(1);
								end
							end
						endcase
					end
				end
				S_ORD: state_q <= S_OLD;
				S_OLD: begin
					res_q   <= '{index: 3'(i_q), solution: rhs_rdata, failed: 1'b0,
						final_res: (i_q + CW'(1) == k_q)};
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (res_ready) begin
						if (i_q + CW'(1) == k_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= S_ORD;
						end
					end
				end
				S_FAIL: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ld_ready  = state_q == S_IDLE;
	assign res_valid = state_q == S_EMIT || state_q == S_FAIL;
	assign res_item  = res_q;

	`CSOLV_ASSERT_IMP(a_unit_free, clk, arst_n, ureq.start, !ursp.busy)
	`CSOLV_ASSERT_IMP(a_k_range, clk, arst_n, state_q != S_IDLE, k_q != '0 && k_q <= MAX_SIZE)
	`CSOLV_ASSERT_IMP(a_fact_lower, clk, arst_n, state_q != S_IDLE && phase_q == PH_FACT, i_q >= j_q)
	`CSOLV_ASSERT_NXT(a_done_wakes, clk, arst_n, state_q == S_WAIT && ursp.done, state_q == S_RD_S || state_q == S_ORD)

endmodule
`default_nettype wire

// File: sv/cholesky_spd_solver.sv
// Loading: elements are taken while the sequencer is idle. After the last element
// the block factorizes, then runs forward and backward substitution, and then
// emits the results in index order, or one failed result on a non-positive pivot.
// Throughput: one system at a time, bounded by the iterative divide unit.
// Reset: asynchronous, active low; size_q returns to 8, stores undefined.
`default_nettype none
module cholesky_spd_solver #(
	parameter int MAX_SIZE = csolv_pkg::MAX_SIZE
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [3:0]           cfg_data,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire csolv_pkg::in_item_t  item,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output csolv_pkg::out_item_t      result
);

	// The size register is written in any cycle; the contract keeps writes
	// to times when no solve is in flight.
	logic [3:0]           size_q;
	logic                 res_valid;
	logic                 res_ready;
	csolv_pkg::out_item_t res_item;
	logic                 out_valid_q;
	csolv_pkg::out_item_t out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= csolv_pkg::SIZE_RESET;
		end else if (cfg_valid) begin
			size_q <= cfg_data;
		end
	end

	// The sequencer owns both stores and the divide/square-root unit.
	csolv_seq #(.MAX_SIZE(MAX_SIZE)) u_seq (
		.clk(clk), .arst_n(arst_n), .size_cfg(size_q),
		.ld_valid(item_valid), .ld_ready(item_ready), .ld_item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res_item(res_item)
	);

	// Output register: the sequencer hands over a result whenever the
	// register is empty or its current transfer completes in this cycle.
	assign res_ready = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res_item;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire
